// ----- hw/rtl/dark_border_crop_detector_top_assert.svh -----
// Assertion macros for the dark border crop detector top level.
// Expects signals named clk and arst_n in the including scope.
`ifndef DARK_BORDER_CROP_DETECTOR_TOP_ASSERT_SVH
`define DARK_BORDER_CROP_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DBCD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dbcd assertion failed");

// Next-cycle implication, disabled during reset.
`define DBCD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dbcd assertion failed");

`endif

// ----- hw/rtl/dbcd_pkg.sv -----
// Shared types, constants and helper functions for the dark border crop detector.
// No dependencies.
package dbcd_pkg;

	localparam int MAX_WIDTH = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int FIELD_W = 13;
	localparam int ADDR_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int PIX_W = 8;
	localparam int PCT_W = 7;
	localparam int PROD_W = 20;
	localparam int PCT_SCALE = 100;
	localparam int CFG_IDX_W = 3;
	localparam int OUT_DATA_W = ((6 * FIELD_W + 7) / 8) * 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DARK_THRESHOLD = 3'd0,
		REG_FRAME_WIDTH    = 3'd1,
		REG_FRAME_HEIGHT   = 3'd2,
		REG_TOP_PERCENT    = 3'd3,
		REG_BOTTOM_PERCENT = 3'd4,
		REG_SIDE_PERCENT   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0]   dark_threshold;
		logic [FIELD_W-1:0] eff_width;
		logic [FIELD_W-1:0] eff_height;
		logic [PCT_W-1:0]   top_percent;
		logic [PCT_W-1:0]   bottom_percent;
		logic [PCT_W-1:0]   side_percent;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PIX_UPD,
		ST_ROW_MUL,
		ST_ROW_CMP,
		ST_SCAN_MUL,
		ST_SCAN,
		ST_SCAN_DRAIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic pix_capture;
		logic pix_update;
		logic row_mul;
		logic row_cmp;
		logic scan_start;
		logic scan_issue;
		logic out_load;
		logic frame_restart;
	} dp_cmd_t;

	typedef struct packed {
		logic col_last;
		logic row_last;
		logic scan_last;
		logic out_room;
	} dp_stat_t;

	function automatic logic [FIELD_W-1:0] clamp_width(input logic [FIELD_W-1:0] v);
		logic [FIELD_W-1:0] r;
		if (v == '0) begin
			r = FIELD_W'(1);
		end else if (v > FIELD_W'(MAX_WIDTH)) begin
			r = FIELD_W'(MAX_WIDTH);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [FIELD_W-1:0] clamp_height(input logic [FIELD_W-1:0] v);
		logic [FIELD_W-1:0] r;
		if (v == '0) begin
			r = FIELD_W'(1);
		end else if (v > FIELD_W'(MAX_HEIGHT)) begin
			r = FIELD_W'(MAX_HEIGHT);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/dark_border_crop_detector_top.sv -----
// Channel   | Group                         | Word
// ----------+-------------------------------+-------------------------------------------
// pixel in  | s_tvalid s_tready s_tdata     | one grey pixel, raster order
// crop out  | m_tvalid m_tready m_tdata/user| crop rectangle once per frame, status flag
// config    | cfg_valid cfg_ready           | cfg_index selects register, cfg_data value
//
// Each pixel is captured in IDLE and written in PIX_UPD; a row end adds ROW_MUL and ROW_CMP for the row tests.
// The last pixel of a frame adds a column scan of one memory read per column,
// through SCAN_MUL, SCAN, SCAN_DRAIN and OUT, plus any wait for the output register.
// The column count memory needs no clearing pass: the first row writes it outright.
// Reset is asynchronous; a write to either size register restarts the frame.
// Depends on dbcd_pkg, dbcd_cfg, dbcd_ctrl, dbcd_dp and the assertion header.
module dark_border_crop_detector_top
	import dbcd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIX_W-1:0]      s_tdata,   // gray_value
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// top_row, bottom_row, left_col, right_col, crop_width, crop_height, zero fill
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [0:0]            m_tuser,   // status
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [FIELD_W-1:0]    cfg_data
);

	cfg_t     cfg;
	logic     size_wr;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	dbcd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.size_wr   (size_wr)
	);

	dbcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dbcd_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.size_wr  (size_wr),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

`include "dark_border_crop_detector_top_assert.svh"

	`DBCD_ASSERT_NOW(a_no_pixel_in_scan, cmd.scan_issue, !s_tready)
	`DBCD_ASSERT_NOW(a_load_has_room, cmd.out_load, !m_tvalid || m_tready)
	`DBCD_ASSERT_NEXT(a_accept_then_update, s_tvalid && s_tready, cmd.pix_update)

endmodule

// ----- hw/rtl/dbcd_cfg.sv -----
// Configuration register file with size clamping.
// Depends on dbcd_pkg.
module dbcd_cfg
	import dbcd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FIELD_W-1:0]   cfg_data,
	output cfg_t                 cfg,
	output logic                 size_wr
);

	logic [PIX_W-1:0]   thr_q;
	logic [FIELD_W-1:0] width_q;
	logic [FIELD_W-1:0] height_q;
	logic [PCT_W-1:0]   top_pct_q;
	logic [PCT_W-1:0]   bot_pct_q;
	logic [PCT_W-1:0]   side_pct_q;
	logic               wr;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= PIX_W'(10);
			width_q    <= FIELD_W'(640);
			height_q   <= FIELD_W'(480);
			top_pct_q  <= PCT_W'(65);
			bot_pct_q  <= PCT_W'(85);
			side_pct_q <= PCT_W'(80);
		end else if (wr) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DARK_THRESHOLD: thr_q      <= cfg_data[PIX_W-1:0];
				REG_FRAME_WIDTH:    width_q    <= cfg_data;
				REG_FRAME_HEIGHT:   height_q   <= cfg_data;
				REG_TOP_PERCENT:    top_pct_q  <= cfg_data[PCT_W-1:0];
				REG_BOTTOM_PERCENT: bot_pct_q  <= cfg_data[PCT_W-1:0];
				REG_SIDE_PERCENT:   side_pct_q <= cfg_data[PCT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		size_wr = 1'b0;
		if (wr) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH, REG_FRAME_HEIGHT: size_wr = 1'b1;
				default:                           size_wr = 1'b0;
			endcase
		end
	end

	assign cfg.dark_threshold = thr_q;
	assign cfg.eff_width      = clamp_width(width_q);
	assign cfg.eff_height     = clamp_height(height_q);
	assign cfg.top_percent    = top_pct_q;
	assign cfg.bottom_percent = bot_pct_q;
	assign cfg.side_percent   = side_pct_q;

endmodule

// ----- hw/rtl/dbcd_ctrl.sv -----
// Controller state machine sequencing pixel, row, scan and output steps.
// Depends on dbcd_pkg.
module dbcd_ctrl
	import dbcd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_PIX_UPD;
			end
			ST_PIX_UPD: begin
				state_d = stat.col_last ? ST_ROW_MUL : ST_IDLE;
			end
			ST_ROW_MUL: state_d = ST_ROW_CMP;
			ST_ROW_CMP: begin
				state_d = stat.row_last ? ST_SCAN_MUL : ST_IDLE;
			end
			ST_SCAN_MUL: state_d = ST_SCAN;
			ST_SCAN: begin
				if (stat.scan_last) state_d = ST_SCAN_DRAIN;
			end
			ST_SCAN_DRAIN: state_d = ST_OUT;
			ST_OUT: begin
				if (stat.out_room) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.pix_capture = s_tvalid;
			end
			ST_PIX_UPD:  cmd.pix_update = 1'b1;
			ST_ROW_MUL:  cmd.row_mul = 1'b1;
			ST_ROW_CMP:  cmd.row_cmp = 1'b1;
			ST_SCAN_MUL: cmd.scan_start = 1'b1;
			ST_SCAN:     cmd.scan_issue = 1'b1;
			ST_SCAN_DRAIN: begin
			end
			ST_OUT: begin
				cmd.out_load = stat.out_room;
				cmd.frame_restart = stat.out_room;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hw/rtl/dbcd_dp.sv -----
// Datapath: column count memory, row and frame counters, fraction tests, output register.
// Depends on dbcd_pkg.
module dbcd_dp
	import dbcd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  size_wr,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	input  logic [PIX_W-1:0]      s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [0:0]            m_tuser
);

	logic [FIELD_W-1:0] col_mem [MAX_WIDTH];

	logic [ADDR_W-1:0]  col_q;
	logic [ROW_W-1:0]   row_q;
	logic [FIELD_W-1:0] row_cnt_q;
	logic               top_found_q;
	logic [ROW_W-1:0]   top_q;
	logic               bot_found_q;
	logic [ROW_W-1:0]   bot_q;
	logic [ADDR_W-1:0]  sc_q;
	logic               scan_vld_s1;
	logic               found_q;
	logic [FIELD_W-1:0] left_q;
	logic [FIELD_W-1:0] right_q;
	logic               m_tvalid_q;

	logic               nd_q;
	logic [FIELD_W-1:0] mem_rd_s1;
	logic [ADDR_W-1:0]  c_s1;
	logic [PROD_W-1:0]  row_scaled_q;
	logic [PROD_W-1:0]  top_need_q;
	logic [PROD_W-1:0]  bot_need_q;
	logic [PROD_W-1:0]  side_need_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic               m_tuser_q;

	logic               restart;
	logic               mem_we;
	logic [FIELD_W-1:0] mem_wd;
	logic               mem_re;
	logic [ADDR_W-1:0]  mem_ra;
	logic               col_hit;
	logic [FIELD_W-1:0] top_out;
	logic [FIELD_W-1:0] bot_out;
	logic               crossed;
	logic [FIELD_W-1:0] crop_w;
	logic [FIELD_W-1:0] crop_h;

	assign restart = cmd.frame_restart | size_wr;

	assign stat.col_last  = (col_q == ADDR_W'(cfg.eff_width - FIELD_W'(1)));
	assign stat.row_last  = (row_q == ROW_W'(cfg.eff_height - FIELD_W'(1)));
	assign stat.scan_last = (sc_q == ADDR_W'(cfg.eff_width - FIELD_W'(1)));
	assign stat.out_room  = !m_tvalid_q || m_tready;

	// The first row of a frame writes the counts outright, so no clearing pass is needed.
	assign mem_we = cmd.pix_update;
	assign mem_wd = (row_q == '0) ? FIELD_W'(nd_q) : mem_rd_s1 + FIELD_W'(nd_q);
	assign mem_re = cmd.pix_capture | cmd.scan_issue;
	assign mem_ra = cmd.scan_issue ? sc_q : col_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			col_mem[col_q] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_s1 <= col_mem[mem_ra];
		end
	end

	assign col_hit = (PROD_W'(mem_rd_s1) * PROD_W'(PCT_SCALE)) >= side_need_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			row_cnt_q   <= '0;
			top_found_q <= 1'b0;
			top_q       <= '0;
			bot_found_q <= 1'b0;
			bot_q       <= '0;
			sc_q        <= '0;
			scan_vld_s1 <= 1'b0;
			found_q     <= 1'b0;
			left_q      <= '0;
			right_q     <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			scan_vld_s1 <= cmd.scan_issue;
			if (restart) begin
				col_q       <= '0;
				row_q       <= '0;
				row_cnt_q   <= '0;
				top_found_q <= 1'b0;
				top_q       <= '0;
				bot_found_q <= 1'b0;
			end else begin
				if (cmd.pix_update) begin
					row_cnt_q <= row_cnt_q + FIELD_W'(nd_q);
					col_q     <= stat.col_last ? '0 : col_q + ADDR_W'(1);
				end
				if (cmd.row_cmp) begin
					if (!top_found_q && row_scaled_q >= top_need_q) begin
						top_found_q <= 1'b1;
						top_q       <= row_q;
					end
					if (row_scaled_q >= bot_need_q) begin
						bot_found_q <= 1'b1;
						bot_q       <= row_q;
					end
					row_cnt_q <= '0;
					row_q     <= stat.row_last ? '0 : row_q + ROW_W'(1);
				end
			end
			if (cmd.scan_start) begin
				sc_q    <= '0;
				found_q <= 1'b0;
				left_q  <= '0;
				right_q <= cfg.eff_width;
			end else if (cmd.scan_issue) begin
				sc_q <= sc_q + ADDR_W'(1);
			end
			if (scan_vld_s1 && col_hit) begin
				if (!found_q) begin
					left_q <= FIELD_W'(c_s1);
				end
				found_q <= 1'b1;
				right_q <= FIELD_W'(c_s1);
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign top_out = FIELD_W'(top_q);
	assign bot_out = bot_found_q ? FIELD_W'(bot_q) : cfg.eff_height;
	assign crossed = (top_out > bot_out) || (right_q < left_q);
	assign crop_w  = crossed ? '0 : right_q - left_q;
	assign crop_h  = crossed ? '0 : bot_out - top_out;

	always_ff @(posedge clk) begin
		if (cmd.pix_capture) begin
			nd_q <= (s_tdata >= cfg.dark_threshold);
		end
		if (cmd.scan_issue) begin
			c_s1 <= sc_q;
		end
		if (cmd.row_mul) begin
			row_scaled_q <= PROD_W'(row_cnt_q) * PROD_W'(PCT_SCALE);
			top_need_q   <= PROD_W'(cfg.top_percent) * PROD_W'(cfg.eff_width);
			bot_need_q   <= PROD_W'(cfg.bottom_percent) * PROD_W'(cfg.eff_width);
		end
		if (cmd.scan_start) begin
			side_need_q <= PROD_W'(cfg.side_percent) * PROD_W'(cfg.eff_height);
		end
		if (cmd.out_load) begin
			m_tdata_q <= OUT_DATA_W'({crop_h, crop_w, right_q, left_q, bot_out, top_out});
			m_tuser_q <= crossed;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

endmodule
